// ----- rtl/ptcp_pkg.sv -----
// Shared types and constants for the pulse-time code packer.
package ptcp_pkg;

   // Operation codes carried by an input word.
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ENCODE = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   // Fixed field widths.
   localparam int CODE_W   = 15;
   localparam int LEN_W    = 4;
   localparam int TIME_W   = 16;
   localparam int TOL_W    = 8;
   localparam int OUT_W    = 16;
   localparam int COUNT_W  = 5;

   // Tolerance after reset.
   localparam logic [TOL_W-1:0] TOL_RESET = 8'd10;

   // Depth of the command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Command passed from the front part to the back part.
   typedef struct packed {
      logic              flush;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } cmd_type;

endpackage

// ----- rtl/ptcp_req_if.sv -----
// Request channel carrying load, encode and flush words.
interface ptcp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [3:0]  entry_index;
   logic [15:0] entry_time;
   logic [14:0] entry_code;
   logic [3:0]  entry_length;
   logic [15:0] sample_time;

   modport source (output valid, operation, entry_index, entry_time, entry_code,
                   entry_length, sample_time, input ready);
   modport sink (input valid, operation, entry_index, entry_time, entry_code,
                 entry_length, sample_time, output ready);
endinterface

// ----- rtl/ptcp_rsp_if.sv -----
// Response channel carrying packed stream words.
interface ptcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] stream_word;
   logic [4:0]  valid_bits;
   logic        last;

   modport source (output valid, stream_word, valid_bits, last, input ready);
   modport sink (input valid, stream_word, valid_bits, last, output ready);
endinterface

// ----- rtl/ptcp_csr_if.sv -----
// Configuration write channel for the match tolerance register.
interface ptcp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] match_tolerance;

   modport source (output valid, match_tolerance, input ready);
   modport sink (input valid, match_tolerance, output ready);
endinterface

// ----- rtl/ptcp_front.sv -----
// Front part: symbol table, tolerance register and sample classification.
module ptcp_front
   import ptcp_pkg::*;
#(
   parameter int TABLE_ENTRIES    = 16,
   parameter int STREAM_WORD_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   ptcp_req_if.sink     req_chan,
   ptcp_csr_if.sink     csr_chan,
   input  logic         queue_full,
   output logic         push_valid,
   output cmd_type      push_cmd
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   logic [TIME_W-1:0] times_ff   [TABLE_ENTRIES];
   logic [CODE_W-1:0] codes_ff   [TABLE_ENTRIES];
   logic [LEN_W-1:0]  lengths_ff [TABLE_ENTRIES];
   logic [TOL_W-1:0]  tol_ff;

   logic [TABLE_ENTRIES-1:0] hit;
   logic                     found;
   logic [IW-1:0]            sel;
   logic [LEN_W-1:0]         len_clip;
   logic [CODE_W-1:0]        code_mask;
   logic                     accept;
   logic                     load_ok;

   assign req_chan.ready = !queue_full;
   assign csr_chan.ready = 1'b1;
   assign accept = req_chan.valid && req_chan.ready;
   assign load_ok = (32'(req_chan.entry_index) < TABLE_ENTRIES);

   // Window compare against every entry; the window is clipped at zero, not wrapped.
   always_comb begin
      for (int j = 0; j < TABLE_ENTRIES; j++) begin
         hit[j] = ({1'b0, req_chan.sample_time} + {9'd0, tol_ff} >= {1'b0, times_ff[j]})
                  && ({1'b0, req_chan.sample_time} <= {1'b0, times_ff[j]} + {9'd0, tol_ff});
      end
   end

   // Lowest-index match wins.
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int j = TABLE_ENTRIES - 1; j >= 0; j--) begin
         if (hit[j]) begin
            found = 1'b1;
            sel   = IW'(j);
         end
      end
   end

   // Clip the length to a stream word and drop code bits above it.
   always_comb begin
      len_clip = lengths_ff[sel];
      if (32'(lengths_ff[sel]) > STREAM_WORD_BITS) begin
         len_clip = LEN_W'(STREAM_WORD_BITS);
      end
      for (int i = 0; i < CODE_W; i++) begin
         code_mask[i] = codes_ff[sel][i] && (i < 32'(len_clip));
      end
   end

   // Classify the accepted word into a command for the back part.
   always_comb begin
      push_valid     = 1'b0;
      push_cmd.flush = 1'b0;
      push_cmd.code  = code_mask;
      push_cmd.len   = len_clip;
      unique case (req_chan.operation)
         OP_ENCODE: begin
            push_valid = accept && (req_chan.sample_time != '0) && found
                         && (len_clip != '0);
         end
         OP_FLUSH: begin
            push_valid     = accept;
            push_cmd.flush = 1'b1;
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

   // Table writes and the tolerance register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
         for (int j = 0; j < TABLE_ENTRIES; j++) begin
            times_ff[j]   <= '0;
            codes_ff[j]   <= '0;
            lengths_ff[j] <= '0;
         end
      end else begin
         if (csr_chan.valid) begin
            tol_ff <= csr_chan.match_tolerance;
         end
         if (accept && (req_chan.operation == OP_LOAD) && load_ok) begin
            times_ff[IW'(req_chan.entry_index)]   <= req_chan.entry_time;
            codes_ff[IW'(req_chan.entry_index)]   <= req_chan.entry_code;
            lengths_ff[IW'(req_chan.entry_index)] <= req_chan.entry_length;
         end
      end
   end

endmodule

// ----- rtl/ptcp_queue.sv -----
// Short command queue between the front and back parts.
module ptcp_queue
   import ptcp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output cmd_type head_cmd
);

   cmd_type           slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = slots_ff[rd_ptr_ff];
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;

   // Storage has no reset; only pointers and count are cleared.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Pointer and occupancy tracking.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- rtl/ptcp_back.sv -----
// Back part: bit accumulator, word packing and the output register.
module ptcp_back
   import ptcp_pkg::*;
#(
   parameter int STREAM_WORD_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     empty,
   input  cmd_type  head_cmd,
   output logic     pop,
   ptcp_rsp_if.source rsp_chan
);

   localparam int W  = STREAM_WORD_BITS;
   localparam int FW = $clog2(W + 1);

   logic [W-1:0]       acc_ff,  acc_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic               out_valid_ff;
   logic [OUT_W-1:0]   word_ff,  word_in;
   logic [COUNT_W-1:0] bits_ff,  bits_in;
   logic               last_ff,  last_in;
   logic               emit;

   logic [2*W-1:0] merged;
   logic [FW:0]    total;
   logic [FW-1:0]  rem;
   logic [FW-1:0]  pad;
   logic [W-1:0]   full_word;

   // Advance whenever the output slot is free or being drained.
   assign pop = !empty && (!out_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.stream_word = word_ff;
   assign rsp_chan.valid_bits  = bits_ff;
   assign rsp_chan.last        = last_ff;

   // Append and flush datapath.
   always_comb begin
      merged    = ({{W{1'b0}}, acc_ff} << head_cmd.len)
                  | {{(2*W-CODE_W){1'b0}}, head_cmd.code};
      total     = (FW+1)'(fill_ff) + (FW+1)'(head_cmd.len);
      rem       = FW'(total - (FW+1)'(W));
      pad       = FW'(W) - fill_ff;
      full_word = W'(merged >> rem);
      acc_in    = acc_ff;
      fill_in   = fill_ff;
      word_in   = word_ff;
      bits_in   = bits_ff;
      last_in   = last_ff;
      emit      = 1'b0;
      if (head_cmd.flush) begin
         if (fill_ff != '0) begin
            emit    = 1'b1;
            word_in = OUT_W'(acc_ff << pad);
            bits_in = COUNT_W'(fill_ff);
            last_in = 1'b1;
         end
         acc_in  = '0;
         fill_in = '0;
      end else if (total < (FW+1)'(W)) begin
         acc_in  = W'(merged);
         fill_in = FW'(total);
      end else begin
         emit    = 1'b1;
         word_in = OUT_W'(full_word);
         bits_in = COUNT_W'(W);
         last_in = 1'b0;
         acc_in  = W'(merged) & ~({W{1'b1}} << rem);
         fill_in = rem;
      end
   end

   // Accumulator state and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            acc_ff  <= acc_in;
            fill_ff <= fill_in;
         end
         // A new stream word takes the output slot; otherwise a drained slot empties.
         if (pop && emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (pop && emit) begin
         word_ff <= word_in;
         bits_ff <= bits_in;
         last_ff <= last_in;
      end
   end

endmodule

// ----- rtl/pulse_time_code_packer_unit.sv -----
// Pulse-time code packer: matches pulse samples to table codes and packs them.
//
// Use: words on req_chan load table entries, encode samples or flush the
// partial stream word. A sample matches the lowest-index entry whose time lies
// within plus or minus the match tolerance; its code is packed MSB first into
// stream words that leave on rsp_chan. csr_chan writes the tolerance and is
// always ready; write it only while the block is idle.
// Throughput: one request word per cycle unless the command queue is full, and
// one stream word per cycle unless rsp_chan stalls; set by the parallel table
// compare in the front part and the back part's combinational merge shifter.
// Path: a word that completes a stream word enters the command queue when it
// is accepted and moves into the output register once it heads the queue and
// the output slot is free or draining; the stream word then shows on rsp_chan.
// Reset: the table is cleared to zero, the tolerance returns to 10 and the
// accumulator is emptied.
// Stall: while rsp_chan is stalled the back part holds its output; the front
// part keeps accepting until the four-entry command queue fills, then drops
// req_chan.ready.
module pulse_time_code_packer_unit
   import ptcp_pkg::*;
#(
   parameter int TABLE_ENTRIES    = 16,
   parameter int STREAM_WORD_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   ptcp_req_if.sink   req_chan,
   ptcp_csr_if.sink   csr_chan,
   ptcp_rsp_if.source rsp_chan
);

   logic    push_valid;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   cmd_type head_cmd;

   // Classification and table lookup.
   ptcp_front #(
      .TABLE_ENTRIES    (TABLE_ENTRIES),
      .STREAM_WORD_BITS (STREAM_WORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // Decoupling queue.
   ptcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .empty      (queue_empty),
      .pop        (pop),
      .head_cmd   (head_cmd)
   );

   // Packing and output.
   ptcp_back #(
      .STREAM_WORD_BITS (STREAM_WORD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (queue_empty),
      .head_cmd (head_cmd),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
